// ===== rtl/core/pngse_pkg.sv =====
package pngse_pkg;

  typedef enum logic [1:0] {
    SRC_HDR,
    SRC_FILT,
    SRC_SAMP,
    SRC_FIN
  } byte_src_t;

  typedef struct packed {
    logic      emit;
    byte_src_t src;
    logic [5:0] idx;
    logic      last;
    logic      eof;
    logic      start;
    logic      take;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic div_done;
    logic blk_pend;
    logic raw_last;
    logic line_head;
  } status_t;

  localparam logic [5:0] HDR_LAST_IDX = 6'd42;
  localparam logic [5:0] HDR_IDAT_LEN_IDX = 6'd33;
  localparam logic [5:0] FIN_LAST_IDX = 6'd19;
  localparam logic [2:0] BLK_LAST_IDX = 3'd4;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0: b = 8'd137;
      3'd1: b = 8'd80;
      3'd2: b = 8'd78;
      3'd3: b = 8'd71;
      3'd4: b = 8'd13;
      3'd5: b = 8'd10;
      3'd6: b = 8'd26;
      default: b = 8'd10;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] ihdr_type();
    return 32'h49484452;
  endfunction

  function automatic logic [31:0] idat_type();
    return 32'h49444154;
  endfunction

  function automatic logic [31:0] iend_type();
    return 32'h49454E44;
  endfunction

endpackage

// ===== rtl/core/pngse_ctrl.sv =====
module pngse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pngse_pkg::status_t st,
  output pngse_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_FILT,
    S_SAMP,
    S_FIN
  } state_t;

  state_t     state_r;
  logic [5:0] idx_r;
  logic       started_r;
  logic       emit;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    emit = 1'b0;
    if (state_r != S_IDLE && st.emit_ok) begin
      emit = !(state_r == S_HDR && idx_r == pngse_pkg::HDR_IDAT_LEN_IDX && !st.div_done);
    end
  end

  always_comb begin
    cmd = '0;
    cmd.emit = emit;
    cmd.idx = idx_r;
    cmd.take = in_valid && (state_r == S_IDLE);
    cmd.start = cmd.take && !started_r;
    unique case (state_r)
      S_HDR: cmd.src = pngse_pkg::SRC_HDR;
      S_FILT: cmd.src = pngse_pkg::SRC_FILT;
      S_SAMP: begin
        cmd.src = pngse_pkg::SRC_SAMP;
        cmd.last = !st.blk_pend && !st.raw_last;
      end
      S_FIN: begin
        cmd.src = pngse_pkg::SRC_FIN;
        cmd.last = (idx_r == pngse_pkg::FIN_LAST_IDX);
        cmd.eof = (idx_r == pngse_pkg::FIN_LAST_IDX);
      end
      default: cmd.src = pngse_pkg::SRC_HDR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      started_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            idx_r <= '0;
            started_r <= 1'b1;
            if (!started_r) begin
              state_r <= S_HDR;
            end else begin
              state_r <= st.line_head ? S_FILT : S_SAMP;
            end
          end
        end
        S_HDR: begin
          if (emit) begin
            if (idx_r == pngse_pkg::HDR_LAST_IDX) begin
              idx_r <= '0;
              state_r <= S_FILT;
            end else begin
              idx_r <= idx_r + 6'd1;
            end
          end
        end
        S_FILT: begin
          if (emit) begin
            if (st.blk_pend) begin
              idx_r <= idx_r + 6'd1;
            end else begin
              idx_r <= '0;
              state_r <= S_SAMP;
            end
          end
        end
        S_SAMP: begin
          if (emit) begin
            if (st.blk_pend) begin
              idx_r <= idx_r + 6'd1;
            end else begin
              idx_r <= '0;
              state_r <= st.raw_last ? S_FIN : S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (emit) begin
            if (idx_r == pngse_pkg::FIN_LAST_IDX) begin
              idx_r <= '0;
              started_r <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + 6'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/pngse_datapath.sv =====
module pngse_datapath #(
  parameter int MAX_WIDTH = 8192,
  parameter int MAX_HEIGHT = 8192,
  parameter int STORED_BLOCK_BYTES = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [13:0]        cfg_wdata,
  input  logic [7:0]         in_colour_sample,
  input  pngse_pkg::cmd_t    cmd,
  output pngse_pkg::status_t st,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_last_of_item,
  output logic               out_end_of_file
);

  localparam int RAW_W = 30;
  localparam int PROD_W = RAW_W + 32;
  localparam logic [16:0] BLK = 17'(STORED_BLOCK_BYTES);

  // The block count is a multiplication by a rounded-up reciprocal of the block size.
  // It is exact for every numerator below 2**RAW_W.
  localparam int RCP_LOG = $clog2(STORED_BLOCK_BYTES);
  localparam int RCP_SHIFT = RAW_W + RCP_LOG;
  localparam logic [63:0] RCP_FULL = ((64'd1 << RCP_SHIFT) + 64'(STORED_BLOCK_BYTES) - 64'd1) /
                                     64'(STORED_BLOCK_BYTES);
  localparam logic [31:0] RCP_M = 32'(RCP_FULL);

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_PREP,
    DV_DIV,
    DV_SUM
  } div_state_t;

  logic [13:0]      cfg_w_r, cfg_h_r;
  logic [13:0]      cw_r, ch_r;
  logic [13:0]      cw_nxt, ch_nxt;
  logic [15:0]      row_bytes_r;
  logic [RAW_W-1:0] raw_r, raw_left_r;
  logic [15:0]      blk_left_r;
  logic [15:0]      bir_r;
  logic [31:0]      crc_r, idat_r;
  logic [15:0]      adl_lo_r, adl_hi_r;
  logic [7:0]       sample_r;
  div_state_t       dv_r;
  logic             div_done_r;
  logic [RAW_W-1:0] num_r;
  logic [31:0]      blocks_r;
  logic             out_valid_r, last_r, eof_r;
  logic [7:0]       out_byte_r;

  logic [7:0]        byte_nxt;
  logic              crc_en, crc_rst, raw_emit;
  logic [31:0]       crc_base, crc_nxt;
  logic [15:0]       len_nxt;
  logic              final_nxt;
  logic [16:0]       lo_s, hi_s;
  logic [15:0]       lo_nxt, hi_nxt;
  logic [5:0]        idx;
  logic [15:0]       bir_inc;
  logic [PROD_W-1:0] prod;

  assign idx = cmd.idx;

  always_comb begin
    cw_nxt = (cfg_w_r == 14'd0) ? 14'd1 : cfg_w_r;
    if (32'(cw_nxt) > 32'(MAX_WIDTH)) cw_nxt = 14'(MAX_WIDTH);
    ch_nxt = (cfg_h_r == 14'd0) ? 14'd1 : cfg_h_r;
    if (32'(ch_nxt) > 32'(MAX_HEIGHT)) ch_nxt = 14'(MAX_HEIGHT);
  end

  always_comb begin
    final_nxt = 32'(raw_left_r) <= 32'(STORED_BLOCK_BYTES);
    len_nxt = (32'(raw_left_r) < 32'(STORED_BLOCK_BYTES)) ? 16'(raw_left_r) : 16'(BLK);
  end

  assign st.emit_ok = !out_valid_r || out_ready;
  assign st.div_done = div_done_r;
  assign st.blk_pend = (blk_left_r == 16'd0);
  assign st.raw_last = (raw_left_r == RAW_W'(1));
  assign st.line_head = (bir_r == 16'd0);

  always_comb begin
    byte_nxt = 8'd0;
    crc_en = 1'b0;
    crc_rst = 1'b0;
    raw_emit = 1'b0;
    case (cmd.src)
      pngse_pkg::SRC_HDR: begin
        if (idx < 6'd8) begin
          byte_nxt = pngse_pkg::sig_byte(idx[2:0]);
        end else if (idx < 6'd12) begin
          byte_nxt = pngse_pkg::be_byte(32'd13, idx[1:0]);
        end else if (idx < 6'd16) begin
          byte_nxt = pngse_pkg::be_byte(pngse_pkg::ihdr_type(), idx[1:0]);
          crc_en = 1'b1;
          crc_rst = (idx == 6'd12);
        end else if (idx < 6'd20) begin
          byte_nxt = pngse_pkg::be_byte({18'd0, cw_r}, idx[1:0]);
          crc_en = 1'b1;
        end else if (idx < 6'd24) begin
          byte_nxt = pngse_pkg::be_byte({18'd0, ch_r}, idx[1:0]);
          crc_en = 1'b1;
        end else if (idx < 6'd29) begin
          byte_nxt = (idx == 6'd24) ? 8'd8 : ((idx == 6'd25) ? 8'd2 : 8'd0);
          crc_en = 1'b1;
        end else if (idx < 6'd33) begin
          byte_nxt = pngse_pkg::be_byte(~crc_r, 2'(idx - 6'd29));
        end else if (idx < 6'd37) begin
          byte_nxt = pngse_pkg::be_byte(idat_r, 2'(idx - 6'd33));
        end else if (idx < 6'd41) begin
          byte_nxt = pngse_pkg::be_byte(pngse_pkg::idat_type(), 2'(idx - 6'd37));
          crc_en = 1'b1;
          crc_rst = (idx == 6'd37);
        end else begin
          byte_nxt = (idx == 6'd41) ? 8'h78 : 8'h01;
          crc_en = 1'b1;
        end
      end
      pngse_pkg::SRC_FIN: begin
        if (idx < 6'd4) begin
          byte_nxt = pngse_pkg::be_byte({adl_hi_r, adl_lo_r}, idx[1:0]);
          crc_en = 1'b1;
        end else if (idx < 6'd8) begin
          byte_nxt = pngse_pkg::be_byte(~crc_r, idx[1:0]);
        end else if (idx < 6'd12) begin
          byte_nxt = 8'd0;
        end else if (idx < 6'd16) begin
          byte_nxt = pngse_pkg::be_byte(pngse_pkg::iend_type(), idx[1:0]);
          crc_en = 1'b1;
          crc_rst = (idx == 6'd12);
        end else begin
          byte_nxt = pngse_pkg::be_byte(~crc_r, idx[1:0]);
        end
      end
      default: begin
        crc_en = 1'b1;
        if (blk_left_r == 16'd0) begin
          case (idx[2:0])
            3'd0: byte_nxt = {7'd0, final_nxt};
            3'd1: byte_nxt = len_nxt[7:0];
            3'd2: byte_nxt = len_nxt[15:8];
            3'd3: byte_nxt = ~len_nxt[7:0];
            default: byte_nxt = ~len_nxt[15:8];
          endcase
        end else begin
          raw_emit = 1'b1;
          byte_nxt = (cmd.src == pngse_pkg::SRC_SAMP) ? sample_r : 8'd0;
        end
      end
    endcase
  end

  always_comb begin
    crc_base = crc_rst ? pngse_pkg::CRC_INIT : crc_r;
    crc_nxt = pngse_pkg::crc_byte(crc_base, byte_nxt);
    lo_s = 17'(adl_lo_r) + 17'(byte_nxt);
    lo_nxt = (lo_s >= pngse_pkg::ADLER_MOD) ? 16'(lo_s - pngse_pkg::ADLER_MOD) : 16'(lo_s);
    hi_s = 17'(adl_hi_r) + 17'(lo_nxt);
    hi_nxt = (hi_s >= pngse_pkg::ADLER_MOD) ? 16'(hi_s - pngse_pkg::ADLER_MOD) : 16'(hi_s);
    bir_inc = bir_r + 16'd1;
    prod = PROD_W'(num_r) * PROD_W'(RCP_M);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= 14'd1;
      cfg_h_r <= 14'd1;
      out_valid_r <= 1'b0;
      dv_r <= DV_IDLE;
      div_done_r <= 1'b0;
      blk_left_r <= '0;
      bir_r <= '0;
      raw_left_r <= '0;
      crc_r <= pngse_pkg::CRC_INIT;
      adl_lo_r <= 16'd1;
      adl_hi_r <= 16'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) cfg_h_r <= cfg_wdata;
        else cfg_w_r <= cfg_wdata;
      end
      if (cmd.take) sample_r <= in_colour_sample;
      if (cmd.start) begin
        cw_r <= cw_nxt;
        ch_r <= ch_nxt;
        dv_r <= DV_MUL;
        div_done_r <= 1'b0;
        blk_left_r <= '0;
        bir_r <= '0;
        adl_lo_r <= 16'd1;
        adl_hi_r <= 16'd0;
      end else begin
        case (dv_r)
          DV_MUL: begin
            raw_r <= RAW_W'(32'(ch_r) * (32'd1 + 32'd3 * 32'(cw_r)));
            row_bytes_r <= 16'(32'd3 * 32'(cw_r));
            dv_r <= DV_PREP;
          end
          DV_PREP: begin
            num_r <= raw_r + RAW_W'(STORED_BLOCK_BYTES - 1);
            raw_left_r <= raw_r;
            dv_r <= DV_DIV;
          end
          DV_DIV: begin
            blocks_r <= 32'(prod >> RCP_SHIFT);
            dv_r <= DV_SUM;
          end
          DV_SUM: begin
            idat_r <= 32'd6 + 32'(raw_r) + (blocks_r << 2) + blocks_r;
            div_done_r <= 1'b1;
            dv_r <= DV_IDLE;
          end
          default: dv_r <= DV_IDLE;
        endcase
        if (cmd.emit) begin
          if (crc_en) crc_r <= crc_nxt;
          if (cmd.src == pngse_pkg::SRC_FILT || cmd.src == pngse_pkg::SRC_SAMP) begin
            if (blk_left_r == 16'd0 && idx[2:0] == pngse_pkg::BLK_LAST_IDX) begin
              blk_left_r <= len_nxt;
            end
          end
          if (raw_emit) begin
            adl_lo_r <= lo_nxt;
            adl_hi_r <= hi_nxt;
            blk_left_r <= blk_left_r - 16'd1;
            raw_left_r <= raw_left_r - RAW_W'(1);
            if (cmd.src == pngse_pkg::SRC_SAMP) begin
              bir_r <= (bir_inc >= row_bytes_r) ? 16'd0 : bir_inc;
            end
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= byte_nxt;
      last_r <= cmd.last;
      eof_r <= cmd.eof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_last_of_item = last_r;
  assign out_end_of_file = eof_r;

endmodule

// ===== rtl/core/png_stored_image_encoder_top.sv =====
// Encodes 8-bit RGB samples into an uncompressed PNG byte stream.
// The input channel takes one colour sample per word, red, green, blue, rows top to
// bottom. The output channel gives one file byte per word, with a flag on the last
// byte caused by a sample and a flag on the last byte of the file.
// The configuration port sets width (index 0) and height (index 1); the sizes are
// latched at the first sample of an image and are clamped to 1..MAX.
// The first sample of an image produces 43 header bytes; the IDAT length is computed
// after it in multiply, prepare, divide and sum steps, from a product and a reciprocal
// multiplication, well before its bytes are due. A sample's bytes are emitted one per
// cycle while the receiver accepts them; the next sample is taken once all are emitted:
// one byte for a mid-row sample, more at a row start, a stored-block start, or the
// image end (20 trailer bytes). The output register lets the next sample be taken
// while the final byte still waits. When the receiver stalls, byte generation pauses.
// Reset clears all control state; sizes return to 1 x 1 and the next sample starts
// a new image. After the last sample the next sample starts another image.
module png_stored_image_encoder_top #(
  parameter int MAX_WIDTH = 8192,
  parameter int MAX_HEIGHT = 8192,
  parameter int STORED_BLOCK_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_colour_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_item,
  output logic        out_end_of_file
);

  pngse_pkg::cmd_t    cmd;
  pngse_pkg::status_t st;

  pngse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pngse_datapath #(
    .MAX_WIDTH          (MAX_WIDTH),
    .MAX_HEIGHT         (MAX_HEIGHT),
    .STORED_BLOCK_BYTES (STORED_BLOCK_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_colour_sample (in_colour_sample),
    .cmd              (cmd),
    .st               (st),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_end_of_file  (out_end_of_file)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam bit REG_WIDTH = 1'b0;
  localparam bit REG_HEIGHT = 1'b1;
  localparam int unsigned LIMIT_W = 8192;
  localparam int unsigned LIMIT_H = 8192;
  localparam longint unsigned BLOCK_MAX = 65535;
  localparam bit [31:0] TAG_IHDR = 32'h49484452;
  localparam bit [31:0] TAG_IDAT = 32'h49444154;
  localparam bit [31:0] TAG_IEND = 32'h49454E44;
  localparam int DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    bit [7:0] data;
    bit       last;
    bit       eof;
  } file_byte_t;

  class png_scoreboard;
    int unsigned reg_w = 1, reg_h = 1, cur_w = 1, cur_h = 1;
    bit in_image;
    bit [31:0] crc;
    int unsigned adler_lo, adler_hi, col;
    longint unsigned blk_left, raw_left;
    bit [7:0] burst[$];
    file_byte_t file_q[$];
    int errors;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(bit idx, int unsigned v);
      if (idx == REG_WIDTH) reg_w = v & 14'h3FFF;
      else reg_h = v & 14'h3FFF;
    endfunction

    function void put(bit [7:0] b, bit crc_on);
      if (crc_on) begin
        crc ^= {24'd0, b};
        for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ 32'hEDB88320) : (crc >> 1);
      end
      burst.insert(burst.size(), b);
    endfunction

    function void put32(bit [31:0] w, bit crc_on);
      for (int i = 3; i >= 0; i--) put(w[i*8 +: 8], crc_on);
    endfunction

    function void put_raw(bit [7:0] b);
      longint unsigned len;
      if (blk_left == 0) begin
        len = (raw_left < BLOCK_MAX) ? raw_left : BLOCK_MAX;
        put((len == raw_left) ? 8'd1 : 8'd0, 1);
        put(len[7:0], 1);
        put(len[15:8], 1);
        put(~len[7:0], 1);
        put(~len[15:8], 1);
        blk_left = len;
      end
      put(b, 1);
      adler_lo = (adler_lo + b) % 65521;
      adler_hi = (adler_hi + adler_lo) % 65521;
      if (blk_left > 0) blk_left--;
      if (raw_left > 0) raw_left--;
    endfunction

    function void start_image();
      longint unsigned blocks;
      bit [7:0] sig[8] = '{137, 80, 78, 71, 13, 10, 26, 10};
      cur_w = (reg_w == 0) ? 1 : (reg_w > LIMIT_W ? LIMIT_W : reg_w);
      cur_h = (reg_h == 0) ? 1 : (reg_h > LIMIT_H ? LIMIT_H : reg_h);
      raw_left = longint'(cur_h) * (1 + 3 * longint'(cur_w));
      blocks = (raw_left + BLOCK_MAX - 1) / BLOCK_MAX;
      foreach (sig[i]) put(sig[i], 0);
      put32(32'd13, 0);
      crc = 32'hFFFFFFFF;
      put32(TAG_IHDR, 1);
      put32(cur_w, 1);
      put32(cur_h, 1);
      put(8'd8, 1);
      put(8'd2, 1);
      put(8'd0, 1);
      put(8'd0, 1);
      put(8'd0, 1);
      put32(~crc, 0);
      put32(32'(2 + 5 * blocks + raw_left + 4), 0);
      crc = 32'hFFFFFFFF;
      put32(TAG_IDAT, 1);
      put(8'h78, 1);
      put(8'h01, 1);
      adler_lo = 1;
      adler_hi = 0;
      col = 0;
      blk_left = 0;
      in_image = 1;
    endfunction

    function void note_sample(bit [7:0] s);
      bit done;
      file_byte_t fb;
      burst.delete();
      done = 0;
      if (!in_image) start_image();
      if (col == 0) put_raw(8'd0);
      put_raw(s);
      col++;
      if (col >= 3 * cur_w) col = 0;
      if (raw_left == 0) begin
        put32({adler_hi[15:0], adler_lo[15:0]}, 1);
        put32(~crc, 0);
        put32(32'd0, 0);
        crc = 32'hFFFFFFFF;
        put32(TAG_IEND, 1);
        put32(~crc, 0);
        in_image = 0;
        done = 1;
      end
      foreach (burst[k]) begin
        fb.data = burst[k];
        fb.last = (k == burst.size() - 1);
        fb.eof = fb.last && done;
        file_q.insert(file_q.size(), fb);
      end
    endfunction

    task check_byte(bit [7:0] b, bit last, bit eof);
      file_byte_t fb;
      if (file_q.size() == 0) begin
        report($sformatf("unexpected byte %02h", b));
        return;
      end
      fb = file_q.pop_front();
      if (b !== fb.data) report($sformatf("byte %02h, want %02h", b, fb.data));
      if (last !== fb.last) report($sformatf("last_of_item %0b, want %0b", last, fb.last));
      if (eof !== fb.eof) report($sformatf("end_of_file %0b, want %0b", eof, fb.eof));
    endtask
  endclass

  logic clk = 0, rst_n;
  logic cfg_we, cfg_index;
  logic [13:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [7:0] in_colour_sample;
  logic out_valid, out_ready;
  logic [7:0] out_byte;
  logic out_last_of_item, out_end_of_file;

  png_scoreboard sb = new();
  bit gaps_on = 1;
  longint cycles = 0;

  png_stored_image_encoder_top dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = gaps_on ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.check_byte(out_byte, out_last_of_item, out_end_of_file);
    end
  end

  task automatic set_sizes(int unsigned w, int unsigned h);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= 14'(w);
    @(posedge clk);
    sb.set_reg(REG_WIDTH, w);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= 14'(h);
    @(posedge clk);
    sb.set_reg(REG_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(bit [7:0] s);
    int n;
    n = gaps_on ? $urandom_range(0, 16) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_colour_sample <= s;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_sample(s);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (sb.file_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_image(int unsigned count);
    for (int i = 0; i < count; i++) send_sample(8'($urandom_range(0, 255)));
    drain();
  endtask

  initial begin
    int unsigned w, h, sent, cnt;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_colour_sample <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(8'h00); send_sample(8'hFF); send_sample(8'h5A);
    drain();
    send_sample(8'hFF); send_sample(8'h00); send_sample(8'h81);
    drain();
    set_sizes(0, 0);
    send_sample(8'hAA); send_sample(8'h55); send_sample(8'h0F);
    drain();
    set_sizes(2, 2);
    send_image(12);

    sent = 0;
    while (sent < 110) begin
      w = $urandom_range(1, 5);
      h = $urandom_range(1, 4);
      gaps_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) != 0) set_sizes(w, h);
      cnt = 3 * ((sb.reg_w == 0) ? 1 : sb.reg_w) * ((sb.reg_h == 0) ? 1 : sb.reg_h);
      send_image(cnt);
      sent += cnt;
    end

    if (sb.file_q.size() != 0) sb.report($sformatf("%0d bytes never came", sb.file_q.size()));
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
